[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define TLR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication under reset.
`define TLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[src/tlr_pkg.sv]
// Types and constants shared by the telnet line receiver.
package tlr_pkg;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_ERROR = 2'd2;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_LINE  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_CR   = 8'd13;

    localparam logic [7:0] END_ORDERLY = 8'd0;
    localparam logic [7:0] END_ERROR   = 8'd1;

    localparam logic [7:0] LIMIT_RESET = 8'd31;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [7:0] position;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [7:0] position;
    } res_t;

    // One request's worth of results, count in 1..3.
    typedef struct packed {
        logic [1:0] count;
        res_t [2:0] res;
    } cmd_t;

endpackage

[src/tlr_front.sv]
// Front end: accepts requests, tracks telnet phase and line fill, builds result sets.
module tlr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tlr_pkg::in_t  in_data,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata,
    input  logic          q_full,
    output logic          push,
    output tlr_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        PH_DATA,
        PH_CMD,
        PH_OPT
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       refuse_will_reg, refuse_will_next;
    logic [7:0] line_count_reg, line_count_next;
    logic [7:0] line_limit_reg;
    logic       accept;
    logic [7:0] count_inc;
    logic       hit_limit;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign count_inc = line_count_reg + 8'd1;
    assign hit_limit = (count_inc >= line_limit_reg);

    always_comb
    begin
        phase_next       = phase_reg;
        refuse_will_next = refuse_will_reg;
        line_count_next  = line_count_reg;
        cmd              = '0;

        if (in_data.op != tlr_pkg::OP_BYTE)
        begin
            cmd.count          = 2'd1;
            cmd.res[0].kind    = tlr_pkg::KIND_END;
            cmd.res[0].value   = (in_data.op == tlr_pkg::OP_CLOSE && phase_reg == PH_DATA)
                                 ? tlr_pkg::END_ORDERLY : tlr_pkg::END_ERROR;
            phase_next         = PH_DATA;
            refuse_will_next   = 1'b0;
            line_count_next    = 8'd0;
        end
        else
        begin
            case (phase_reg)
                PH_CMD:
                begin
                    phase_next = PH_DATA;
                    if (in_data.rx_byte == tlr_pkg::TN_IAC)
                    begin
                        cmd.count           = hit_limit ? 2'd2 : 2'd1;
                        cmd.res[0].kind     = tlr_pkg::KIND_DATA;
                        cmd.res[0].value    = in_data.rx_byte;
                        cmd.res[0].position = line_count_reg;
                        cmd.res[1].kind     = tlr_pkg::KIND_LINE;
                        cmd.res[1].position = count_inc;
                        line_count_next     = hit_limit ? 8'd0 : count_inc;
                    end
                    else if (in_data.rx_byte == tlr_pkg::TN_DO
                             || in_data.rx_byte == tlr_pkg::TN_DONT)
                    begin
                        refuse_will_next = 1'b0;
                        phase_next       = PH_OPT;
                    end
                    else if (in_data.rx_byte == tlr_pkg::TN_WILL
                             || in_data.rx_byte == tlr_pkg::TN_WONT)
                    begin
                        refuse_will_next = 1'b1;
                        phase_next       = PH_OPT;
                    end
                end
                PH_OPT:
                begin
                    cmd.count        = 2'd3;
                    cmd.res[0].kind  = tlr_pkg::KIND_REPLY;
                    cmd.res[0].value = tlr_pkg::TN_IAC;
                    cmd.res[1].kind  = tlr_pkg::KIND_REPLY;
                    cmd.res[1].value = refuse_will_reg ? tlr_pkg::TN_DONT : tlr_pkg::TN_WONT;
                    cmd.res[2].kind  = tlr_pkg::KIND_REPLY;
                    cmd.res[2].value = in_data.rx_byte;
                    phase_next       = PH_DATA;
                end
                default:
                begin
                    phase_next = PH_DATA;
                    if (in_data.rx_byte == tlr_pkg::TN_IAC)
                    begin
                        phase_next = PH_CMD;
                    end
                    else if (in_data.rx_byte == tlr_pkg::CH_LF)
                    begin
                        cmd.count           = 2'd1;
                        cmd.res[0].kind     = tlr_pkg::KIND_LINE;
                        cmd.res[0].position = line_count_reg;
                        line_count_next     = 8'd0;
                    end
                    else if (in_data.rx_byte != tlr_pkg::CH_CR)
                    begin
                        cmd.count           = hit_limit ? 2'd2 : 2'd1;
                        cmd.res[0].kind     = tlr_pkg::KIND_DATA;
                        cmd.res[0].value    = in_data.rx_byte;
                        cmd.res[0].position = line_count_reg;
                        cmd.res[1].kind     = tlr_pkg::KIND_LINE;
                        cmd.res[1].position = count_inc;
                        line_count_next     = hit_limit ? 8'd0 : count_inc;
                    end
                end
            endcase
        end
    end

    assign push = accept && (cmd.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_DATA;
            refuse_will_reg <= 1'b0;
            line_count_reg  <= 8'd0;
            line_limit_reg  <= tlr_pkg::LIMIT_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                refuse_will_reg <= refuse_will_next;
                line_count_reg  <= line_count_next;
            end
            if (cfg_we)
            begin
                line_limit_reg <= cfg_wdata;
            end
        end
    end

endmodule

[src/tlr_queue.sv]
// Short queue of result sets between front and back ends.
module tlr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tlr_pkg::cmd_t push_data,
    input  logic          pop,
    output tlr_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    tlr_pkg::cmd_t                   store_reg [tlr_pkg::QUEUE_DEPTH];
    logic [tlr_pkg::QUEUE_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [tlr_pkg::QUEUE_CW-1:0]    count_reg, count_next;
    logic                            do_push, do_pop;

    assign full    = (count_reg == tlr_pkg::QUEUE_CW'(tlr_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = store_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

[src/tlr_back.sv]
// Back end: unpacks each result set into single results behind an output register.
module tlr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  tlr_pkg::cmd_t head,
    input  logic          empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output tlr_pkg::out_t out_data
);

    logic [1:0]    idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    tlr_pkg::out_t out_data_reg, out_data_next;
    tlr_pkg::res_t sel;
    logic          load;
    logic          final_res;

    assign load      = !out_valid_reg || out_ready;
    assign final_res = (idx_reg == (head.count - 2'd1));

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel = head.res[0];
            2'd1:    sel = head.res[1];
            2'd2:    sel = head.res[2];
            default: sel = head.res[0];
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = !empty;
            if (!empty)
            begin
                out_data_next.kind     = sel.kind;
                out_data_next.value    = sel.value;
                out_data_next.position = sel.position;
                out_data_next.last     = final_res;
                pop                    = final_res;
                idx_next               = final_res ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[src/telnet_line_receiver_core.sv]
// The first result of a request passes through the queue and then the output register.
// Throughput: one result per cycle from the output register while out_ready is high; one
// request per cycle when each gives at most one result; an option refusal gives three results.
// A four-entry queue between front and back ends absorbs result bursts and output stalls.
// Reset: asynchronous, active low; clears phase, line fill, queue and output; limit to 31.
module telnet_line_receiver_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tlr_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output tlr_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata
);

    logic          q_full, q_empty, q_push, q_pop;
    tlr_pkg::cmd_t q_in, q_head;

    tlr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .push      (q_push),
        .cmd       (q_in)
    );

    tlr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    tlr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[src/tlr_checker.sv]
// Port-level checks for the telnet line receiver, bound to the top level.
`include "assert_macros.svh"

module tlr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_ready,
    input tlr_pkg::out_t out_data
);

    logic out_take;

    assign out_take = out_valid && out_ready;

    `TLR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `TLR_ASSERT_NEXT(a_burst_unbroken, clk, rst_n, out_take && !out_data.last, out_valid)
    `TLR_ASSERT_NEXT(a_limit_line, clk, rst_n, out_take && !out_data.last && out_data.kind == tlr_pkg::KIND_DATA, out_data.kind == tlr_pkg::KIND_LINE && out_data.position == $past(out_data.position) + 8'd1)
    `TLR_ASSERT_NEXT(a_refusal_order, clk, rst_n, out_take && !out_data.last && out_data.kind == tlr_pkg::KIND_REPLY && out_data.value == tlr_pkg::TN_IAC, out_data.kind == tlr_pkg::KIND_REPLY && (out_data.value == tlr_pkg::TN_DONT || out_data.value == tlr_pkg::TN_WONT))
    `TLR_ASSERT_IMPLY(a_end_alone, clk, rst_n, out_valid && out_data.kind == tlr_pkg::KIND_END, out_data.last && out_data.position == 8'd0)

endmodule

bind telnet_line_receiver_core tlr_checker u_checker (.*);
